/* sv/rlse_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED line encoder package
// Register indexes, reset values, item codes and the types shared between
// the sequencer, the duty stage and the top level.
// ----------------------------------------------------------------------------
package rlse_pkg;

  // Item codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_HIGH_DUTY   = 2'd0;
  localparam logic [1:0] REG_LOW_DUTY    = 2'd1;
  localparam logic [1:0] REG_RESET_SLOTS = 2'd2;
  localparam logic [1:0] REG_PIXEL_COUNT = 2'd3;

  // Register reset values
  localparam logic [7:0] HIGH_DUTY_RST   = 8'd47;
  localparam logic [7:0] LOW_DUTY_RST    = 8'd25;
  localparam logic [7:0] RESET_SLOTS_RST = 8'd66;
  localparam logic [3:0] PIXEL_COUNT_RST = 4'd8;

  // 32 slots per pixel: 24 colour bits then 8 slots sent as zero bits
  localparam int SLOT_SHIFT = 5;
  localparam logic [4:0] LAST_COLOUR_BIT = 5'd23;

  // Decoded slot, passed from the sequencer to the duty stage
  typedef struct packed {
    logic       is_reset;
    logic       colour;
    logic [4:0] bit_sel;
    logic       frame_end;
  } slot_info_t;

  // Duty compare values
  typedef struct packed {
    logic [7:0] high_duty;
    logic [7:0] low_duty;
  } duty_cfg_t;

endpackage
`default_nettype wire

/* sv/rlse_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED line encoder channels
// Input beat channel (pixel writes and ticks) and output beat channel
// (one compare value per slot), each with valid/ready.
// ----------------------------------------------------------------------------
interface rlse_in_if;
  logic       valid;
  logic       ready;
  logic       cmd;
  logic [2:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, cmd, pixel_index, red, green, blue, input ready);
  modport sink   (input valid, cmd, pixel_index, red, green, blue, output ready);
endinterface

interface rlse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] duty;
  logic       frame_end;

  modport source (output valid, duty, frame_end, input ready);
  modport sink   (input valid, duty, frame_end, output ready);
endinterface
`default_nettype wire

/* sv/rlse_slot_seq.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot sequencer
// Holds the slot position within the frame, wraps it at the frame length
// and decodes the current slot into a pixel address and a bit select.
// ----------------------------------------------------------------------------
module rlse_slot_seq
  import rlse_pkg::*;
#(
  parameter int NUM_PIXELS = 8,
  parameter int POS_W      = 9,
  parameter int PIX_W      = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             tick,
  input  wire logic [7:0]       reset_slots,
  input  wire logic [3:0]       pixel_count,
  output      slot_info_t       info,
  output      logic [PIX_W-1:0] pix_addr
);

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] active;
  logic [POS_W-1:0] frame_len;
  logic [POS_W-1:0] cur;
  logic [POS_W-1:0] gap;
  logic [POS_W-1:0] q;
  logic             last;

  // Clamp the pixel count and work out the frame length
  always_comb begin
    if (pixel_count == 4'd0) begin
      active = POS_W'(1);
    end else if (32'(pixel_count) > NUM_PIXELS) begin
      active = POS_W'(NUM_PIXELS);
    end else begin
      active = POS_W'(pixel_count);
    end
    gap       = POS_W'(reset_slots);
    frame_len = gap + (active << SLOT_SHIFT);
  end

  // Restart a frame that was shortened, find the last slot, decode the slot
  always_comb begin
    cur            = (pos >= frame_len) ? '0 : pos;
    last           = ((cur + POS_W'(1)) == frame_len);
    pos_next       = last ? '0 : cur + POS_W'(1);
    q              = cur - gap;
    info.is_reset  = (cur < gap);
    info.colour    = (q[4:3] != 2'b11);
    info.bit_sel   = q[4:0];
    info.frame_end = last;
    pix_addr       = info.is_reset ? '0 : q[SLOT_SHIFT +: PIX_W];
  end

  // Advance one slot per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (tick) begin
      pos <= pos_next;
    end
  end

endmodule
`default_nettype wire

/* sv/rlse_pixel_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel memory
// Green, red and blue bytes of each pixel, one write and one registered read
// per cycle. A per-entry valid bit makes unwritten pixels read as black.
// ----------------------------------------------------------------------------
module rlse_pixel_mem #(
  parameter int NUM_PIXELS = 8,
  parameter int PIX_W      = 3
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [PIX_W-1:0] wr_addr,
  input  wire logic [23:0]      wr_data,
  input  wire logic             rd_en,
  input  wire logic [PIX_W-1:0] rd_addr,
  output      logic [23:0]      rd_data
);

  logic [23:0]           mem [NUM_PIXELS];
  logic [NUM_PIXELS-1:0] written;
  logic [23:0]           rdata;
  logic                  rvalid;

  // Store the colour and register the read word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Track written entries; reset makes every pixel black
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rvalid  <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rvalid <= written[rd_addr];
      end
    end
  end

  assign rd_data = rvalid ? rdata : 24'd0;

endmodule
`default_nettype wire

/* sv/rlse_duty_stage.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Duty stage
// Holds the decoded slot while the pixel word is read, picks the compare
// value and loads it into the output register.
// ----------------------------------------------------------------------------
module rlse_duty_stage
  import rlse_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        tick,
  input  wire slot_info_t  info,
  input  wire logic [23:0] pix_data,
  input  wire duty_cfg_t   duty_cfg,
  output      logic        can_accept,
  rlse_out_if.source       slot_out
);

  slot_info_t s1_info;
  logic       s1_valid;
  logic       advance;
  logic [7:0] duty_next;
  logic       out_valid;
  logic [7:0] out_duty;
  logic       out_frame_end;

  assign advance    = s1_valid && (!out_valid || slot_out.ready);
  assign can_accept = !s1_valid || advance;

  // Hold the decoded slot while the memory read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      s1_info <= info;
    end
  end

  // Pick the compare value for this slot
  always_comb begin
    if (s1_info.is_reset) begin
      duty_next = 8'd0;
    end else if (s1_info.colour && pix_data[LAST_COLOUR_BIT - s1_info.bit_sel]) begin
      duty_next = duty_cfg.high_duty;
    end else begin
      duty_next = duty_cfg.low_duty;
    end
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (slot_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_duty      <= duty_next;
      out_frame_end <= s1_info.frame_end;
    end
  end

  assign slot_out.valid     = out_valid;
  assign slot_out.duty      = out_duty;
  assign slot_out.frame_end = out_frame_end;

endmodule
`default_nettype wire

/* sv/rgb_led_strip_bit_encoder_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RGB LED strip bit encoder
// Turns a pixel memory into a looping stream of PWM compare values, one per
// LED bit period: a latch gap of reset_slots slots, then 32 slots per pixel.
// ----------------------------------------------------------------------------
// Usage:
//   pixel_in carries beats of two kinds. cmd = write stores green, red and
//   blue for pixel_index (indexes beyond the memory are dropped) and yields
//   nothing. cmd = tick yields exactly one beat on slot_out: the compare
//   value of the next slot and a frame_end flag on the last slot of a frame.
//   Ticks and writes are taken in any mix, one beat per cycle while
//   pixel_in.ready is high. A tick taken passes through the registered
//   pixel memory read and then the output register before its result
//   shows on slot_out. Throughput is one beat per cycle while unstalled.
//   Registers are written through cfg_we / cfg_index / cfg_data; the user
//   must write them only while no beat is in flight (not enforced).
//   Reset clears the slot position to the frame start, makes every pixel
//   black at once and restores the register defaults; no sweep is needed.
//   When slot_out stalls, the output register holds its beat and one more
//   tick is taken into the read stage; pixel_in.ready then drops until the
//   output register is freed.
// ----------------------------------------------------------------------------
module rgb_led_strip_bit_encoder_top
  import rlse_pkg::*;
#(
  parameter int NUM_PIXELS = 8
) (
  input  wire logic       clk,
  input  wire logic       rst,
  rlse_in_if.sink         pixel_in,
  rlse_out_if.source      slot_out,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  localparam int POS_W = $clog2(255 + 32 * NUM_PIXELS + 1);
  localparam int PIX_W = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;

  logic [7:0]       high_duty;
  logic [7:0]       low_duty;
  logic [7:0]       reset_slots;
  logic [3:0]       pixel_count;
  duty_cfg_t        duty_cfg;
  slot_info_t       info;
  logic [PIX_W-1:0] pix_addr;
  logic [23:0]      pix_data;
  logic             can_accept;
  logic             accept;
  logic             tick;
  logic             wr_en;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      high_duty   <= HIGH_DUTY_RST;
      low_duty    <= LOW_DUTY_RST;
      reset_slots <= RESET_SLOTS_RST;
      pixel_count <= PIXEL_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HIGH_DUTY:   high_duty   <= cfg_data;
        REG_LOW_DUTY:    low_duty    <= cfg_data;
        REG_RESET_SLOTS: reset_slots <= cfg_data;
        REG_PIXEL_COUNT: pixel_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign duty_cfg.high_duty = high_duty;
  assign duty_cfg.low_duty  = low_duty;

  // Decode the input beat
  assign pixel_in.ready = can_accept;
  assign accept = pixel_in.valid && can_accept;
  assign tick   = accept && (pixel_in.cmd == CMD_TICK);
  assign wr_en  = accept && (pixel_in.cmd == CMD_WRITE)
                  && (32'(pixel_in.pixel_index) < NUM_PIXELS);

  rlse_slot_seq #(
    .NUM_PIXELS (NUM_PIXELS),
    .POS_W      (POS_W),
    .PIX_W      (PIX_W)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .tick        (tick),
    .reset_slots (reset_slots),
    .pixel_count (pixel_count),
    .info        (info),
    .pix_addr    (pix_addr)
  );

  rlse_pixel_mem #(
    .NUM_PIXELS (NUM_PIXELS),
    .PIX_W      (PIX_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (PIX_W'(pixel_in.pixel_index)),
    .wr_data ({pixel_in.green, pixel_in.red, pixel_in.blue}),
    .rd_en   (tick),
    .rd_addr (pix_addr),
    .rd_data (pix_data)
  );

  rlse_duty_stage u_duty (
    .clk        (clk),
    .rst        (rst),
    .tick       (tick),
    .info       (info),
    .pix_data   (pix_data),
    .duty_cfg   (duty_cfg),
    .can_accept (can_accept),
    .slot_out   (slot_out)
  );

endmodule
`default_nettype wire

/* sv/rlse_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// LED line encoder checker
// Port-level checks on reset, flow and latency, bound to the top level.
// ----------------------------------------------------------------------------
module rlse_checker
  import rlse_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_duty,
  input wire logic       out_frame_end
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid after reset");

  // A stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_duty) && $stable(out_frame_end))
    else $error("stalled output beat changed");

  // With the output register free, the input is always ready
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // A fresh output beat comes from a tick that passed through the read stage
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (in_cmd == CMD_TICK), 2))
    else $error("output beat without a matching tick");

endmodule

bind rgb_led_strip_bit_encoder_top rlse_checker u_rlse_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pixel_in.valid),
  .in_ready      (pixel_in.ready),
  .in_cmd        (pixel_in.cmd),
  .out_valid     (slot_out.valid),
  .out_ready     (slot_out.ready),
  .out_duty      (slot_out.duty),
  .out_frame_end (slot_out.frame_end)
);
`default_nettype wire

/* sim/rgb_led_strip_bit_encoder_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB LED strip bit encoder testbench
// Drives pixel writes and slot ticks into the encoder and keeps a shadow copy
// of the pixel memory, the slot position and the registers to work out the
// compare value and frame flag of every tick. Each slot beat is checked
// against the oldest outstanding prediction. A short directed part comes
// first, then random traffic over several frame settings with random gaps
// and stalls on both channels.
// ----------------------------------------------------------------------------
module rgb_led_strip_bit_encoder_top_tb;
  import rlse_pkg::*;

  localparam int NUM_PIXELS    = 8;
  localparam int PIX_SLOTS     = 32;
  localparam int COLOUR_BITS   = 24;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int PHASE_BEATS   = 215;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct packed {
    logic [7:0] duty;
    logic       frame_end;
  } slot_beat_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  rlse_in_if  pixel_in();
  rlse_out_if slot_out();

  // Shadow state of the encoder
  logic [23:0] pixel_mem [NUM_PIXELS];
  int unsigned slot_pos;
  logic [7:0]  high_duty_sh;
  logic [7:0]  low_duty_sh;
  logic [7:0]  gap_slots_sh;
  logic [3:0]  pixel_count_sh;

  slot_beat_t  expected_slots [$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          idle_on;

  rgb_led_strip_bit_encoder_top #(
    .NUM_PIXELS(NUM_PIXELS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .pixel_in (pixel_in),
    .slot_out (slot_out),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Count cycles and give up at the limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    cycle_count = 0;
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Work out the slot that the next tick sends and advance the position
  function automatic slot_beat_t next_slot_beat();
    int unsigned n_pix;
    int unsigned frame_len;
    int unsigned pos;
    int unsigned ofs;
    int unsigned pix;
    int unsigned bitn;
    slot_beat_t  beat;
    n_pix = 32'(pixel_count_sh);
    if (n_pix == 0) begin
      n_pix = 1;
    end
    if (n_pix > NUM_PIXELS) begin
      n_pix = NUM_PIXELS;
    end
    frame_len = 32'(gap_slots_sh) + PIX_SLOTS * n_pix;
    pos = (slot_pos >= frame_len) ? 0 : slot_pos;
    if (pos < 32'(gap_slots_sh)) begin
      beat.duty = 8'd0;
    end else begin
      ofs  = pos - 32'(gap_slots_sh);
      pix  = ofs / PIX_SLOTS;
      bitn = ofs % PIX_SLOTS;
      if (bitn >= COLOUR_BITS || pix >= NUM_PIXELS) begin
        beat.duty = low_duty_sh;
      end else begin
        beat.duty = pixel_mem[3'(pix)][5'(COLOUR_BITS - 1 - bitn)] ?
                    high_duty_sh : low_duty_sh;
      end
    end
    beat.frame_end = (pos + 1 == frame_len);
    slot_pos = beat.frame_end ? 0 : pos + 1;
    return beat;
  endfunction

  // Slot channel: random stalls, check every beat taken
  initial begin
    slot_beat_t  exp_beat;
    int unsigned stall_left;
    stall_left = 0;
    mismatches = 0;
    slot_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && slot_out.valid && slot_out.ready) begin
        if (expected_slots.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("slot beat with nothing outstanding: duty %0d frame_end %0b",
                     slot_out.duty, slot_out.frame_end);
          end
        end else begin
          exp_beat = expected_slots.pop_front();
          if (slot_out.duty !== exp_beat.duty) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("duty mismatch: expected %0d, got %0d", exp_beat.duty, slot_out.duty);
            end
          end
          if (slot_out.frame_end !== exp_beat.frame_end) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("frame_end mismatch: expected %0b, got %0b",
                       exp_beat.frame_end, slot_out.frame_end);
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        slot_out.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        slot_out.ready <= 1'b0;
      end else begin
        slot_out.ready <= 1'b1;
      end
    end
  end

  // Send one beat on the pixel channel and record what it does
  task automatic send_beat(input logic cmd, input logic [2:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
    end
    if (gap != 0) begin
      pixel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pixel_in.valid       <= 1'b1;
    pixel_in.cmd         <= cmd;
    pixel_in.pixel_index <= idx;
    pixel_in.red         <= r;
    pixel_in.green       <= g;
    pixel_in.blue        <= b;
    do @(posedge clk); while (!pixel_in.ready);
    if (cmd == CMD_WRITE) begin
      pixel_mem[idx] = {g, r, b};
    end else begin
      expected_slots.push_back(next_slot_beat());
    end
  endtask

  task automatic tick();
    send_beat(CMD_TICK, 3'd0, 8'd0, 8'd0, 8'd0);
  endtask

  // Hold the pixel channel until every slot beat is back
  task automatic drain();
    pixel_in.valid <= 1'b0;
    while (expected_slots.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HIGH_DUTY:   high_duty_sh   = data;
      REG_LOW_DUTY:    low_duty_sh    = data;
      REG_RESET_SLOTS: gap_slots_sh   = data;
      REG_PIXEL_COUNT: pixel_count_sh = data[3:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] hi, input logic [7:0] lo,
                            input logic [7:0] gap, input logic [7:0] count);
    write_reg(REG_HIGH_DUTY, hi);
    write_reg(REG_LOW_DUTY, lo);
    write_reg(REG_RESET_SLOTS, gap);
    write_reg(REG_PIXEL_COUNT, count);
  endtask

  // Latch gap right after reset: 66 gap slots with all registers at defaults
  task automatic test_latch_gap();
    tick();
    tick();
    drain();
  endtask

  // Full and empty colour bytes at both ends of the memory, one-pixel frame
  task automatic test_colour_extremes();
    set_config(8'hFF, 8'h00, 8'd0, 8'hF0);
    send_beat(CMD_WRITE, 3'd0, 8'h00, 8'hFF, 8'hFF);
    send_beat(CMD_WRITE, 3'd7, 8'hFF, 8'hFF, 8'hFF);
    repeat (4) tick();
  endtask

  // Writes landing between back-to-back ticks
  task automatic test_write_hazard();
    send_beat(CMD_WRITE, 3'd0, 8'hFF, 8'h00, 8'h00);
    tick();
    send_beat(CMD_WRITE, 3'd0, 8'h00, 8'hFF, 8'h00);
    tick();
    tick();
    drain();
  endtask

  // New compare values mid-frame, pixel count above the memory size
  task automatic test_duty_update();
    set_config(8'h5A, 8'hA5, 8'd0, 8'h0F);
    tick();
    tick();
    drain();
  endtask

  // Random writes and ticks over a range of frame settings
  task automatic test_random_frames();
    logic [2:0] idx;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic       cmd;
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_config(8'd255, 8'd0, 8'd255, 8'd8);
        1: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 8'd0, 8'd1);
        2: set_config(8'd0, 8'd255, 8'($urandom_range(0, 255)), 8'd15);
        3: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'h00);
        default: set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      endcase
      idle_on = (p != 5);
      for (int i = 0; i < PHASE_BEATS; i++) begin
        cmd = ($urandom_range(0, 9) < 7) ? CMD_TICK : CMD_WRITE;
        idx = 3'($urandom_range(0, 7));
        r   = 8'($urandom_range(0, 255));
        g   = 8'($urandom_range(0, 255));
        b   = 8'($urandom_range(0, 255));
        send_beat(cmd, idx, r, g, b);
        // toggle idling now and then so quiet stretches appear
        if (p != 5 && $urandom_range(0, 63) == 0) begin
          idle_on = !idle_on;
        end
        if ($urandom_range(0, 99) == 0) begin
          drain();
        end
      end
      drain();
    end
  endtask

  initial begin
    foreach (pixel_mem[i]) begin
      pixel_mem[i] = 24'd0;
    end
    slot_pos       = 0;
    high_duty_sh   = HIGH_DUTY_RST;
    low_duty_sh    = LOW_DUTY_RST;
    gap_slots_sh   = RESET_SLOTS_RST;
    pixel_count_sh = PIXEL_COUNT_RST;
    idle_on        = 1'b0;

    rst                  <= 1'b1;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_HIGH_DUTY;
    cfg_data             <= 8'd0;
    pixel_in.valid       <= 1'b0;
    pixel_in.cmd         <= CMD_WRITE;
    pixel_in.pixel_index <= 3'd0;
    pixel_in.red         <= 8'd0;
    pixel_in.green       <= 8'd0;
    pixel_in.blue        <= 8'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_latch_gap();
    test_colour_extremes();
    test_write_hazard();
    test_duty_update();
    test_random_frames();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_slots.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/rlse_pkg.sv
sv/rlse_if.sv
sv/rlse_slot_seq.sv
sv/rlse_pixel_mem.sv
sv/rlse_duty_stage.sv
sv/rgb_led_strip_bit_encoder_top.sv
sv/rlse_checker.sv
sim/rgb_led_strip_bit_encoder_top_tb.sv
